>>> src/rfg_pkg.sv
// ----------------------------------------------------------------------------
// rfg_pkg
// Shared widths, constants and cell payload types of the radial fade gray
// converter.
// ----------------------------------------------------------------------------
package rfg_pkg;

	// coordinate width; the d2, distance, radicand, remainder and dividend widths follow from it
	localparam int COORD_BITS = 12;
	localparam int D2_W       = 2 * COORD_BITS + 1;        // dx*dx + dy*dy
	localparam int ROOT_W     = COORD_BITS + 9;            // distance, 8 fraction bits
	localparam int RAD_W      = 2 * ROOT_W;                // radicand d2 << 16
	localparam int REM_W      = ROOT_W + 2;                // square root remainder
	localparam int NUM_W      = ROOT_W + 8;                // dividend dist << 8
	localparam int RADIUS_W   = 13;
	localparam int SUM_W      = 10;
	localparam int FAC_W      = 19;                        // unsigned Q3.16
	localparam int RATIO_W    = 20;
	localparam int PROD_W     = SUM_W + FAC_W;
	localparam int APB_AW     = 4;

	localparam logic [RATIO_W-1:0] RATIO_CLAMP = RATIO_W'(589824);
	localparam logic [FAC_W-1:0]   FAC_MAX     = FAC_W'(524287);
	localparam logic [RATIO_W:0]   Q16_ONE     = (RATIO_W+1)'(65536);
	localparam logic [16:0]        RECIP3      = 17'd43691;   // ceil(2^17 / 3)

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2,
		REG_MODE     = 2'd3
	} reg_idx_t;

	// payload handed along the square root chain
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [SUM_W-1:0]  sum;
	} sqrt_t;

	// payload handed along the divider chain
	typedef struct packed {
		logic [NUM_W-1:0]    nq;   // dividend bits shifting out, quotient shifting in
		logic [RADIUS_W-1:0] rem;
		logic [SUM_W-1:0]    sum;
	} div_t;

endpackage

>>> src/rfg_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rfg_sqrt_cell
// One digit of the restoring square root: takes two radicand bits, yields one
// root bit, and hands the result to the next cell.
// ----------------------------------------------------------------------------
module rfg_sqrt_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rfg_pkg::sqrt_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rfg_pkg::sqrt_t out_data
);
	import rfg_pkg::*;

	logic [REM_W+1:0] rem2;
	logic [REM_W+1:0] trial;
	logic             fits;
	sqrt_t            nxt;
	logic             valid_q;
	sqrt_t            data_q;

	// bring down two bits and try the next root digit
	always_comb begin
		rem2  = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
		trial = (REM_W+2)'({in_data.root, 2'b01});
		fits  = (rem2 >= trial);
		nxt.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
		nxt.rem  = fits ? REM_W'(rem2 - trial) : REM_W'(rem2);
		nxt.root = {in_data.root[ROOT_W-2:0], fits};
		nxt.sum  = in_data.sum;
	end

	assign in_ready = !valid_q || out_ready;

	// advance when the neighbour takes the held request or the cell is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> src/rfg_div_cell.sv
// ----------------------------------------------------------------------------
// rfg_div_cell
// One step of the restoring divider: brings down one dividend bit and yields
// one quotient bit.
// ----------------------------------------------------------------------------
module rfg_div_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rfg_pkg::RADIUS_W-1:0]    divisor,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  rfg_pkg::div_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output rfg_pkg::div_t                   out_data
);
	import rfg_pkg::*;

	logic [RADIUS_W:0] rem2;
	logic              fits;
	div_t              nxt;
	logic              valid_q;
	div_t              data_q;

	// trial subtract of the divisor
	always_comb begin
		rem2 = {in_data.rem, in_data.nq[NUM_W-1]};
		fits = (rem2 >= {1'b0, divisor});
		nxt.rem = fits ? RADIUS_W'(rem2 - {1'b0, divisor}) : RADIUS_W'(rem2);
		nxt.nq  = {in_data.nq[NUM_W-2:0], fits};
		nxt.sum = in_data.sum;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> src/radial_fade_gray_converter.sv
// ----------------------------------------------------------------------------
// radial_fade_gray_converter
// RGB to gray with a radial fade around a programmable centre.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not stalled and
// returns one gray value per pixel, in order. At 12-bit coordinates a pixel
// passes a front register holding the squared offsets, a row of 21 cells
// taking the square root one digit per cell, a row of 29 cells dividing by
// the radius one quotient bit per cell, and a product register and the output
// register that scale and saturate. Every cell holds its request while the
// next one is full, so a stall at the output backs up only as far as the
// pipeline is full. Registers may only be written while no pixel is in flight.
module radial_fade_gray_converter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rfg_pkg::APB_AW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [rfg_pkg::COORD_BITS-1:0] pixel_x,
	input  logic [rfg_pkg::COORD_BITS-1:0] pixel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    gray
);
	import rfg_pkg::*;

	logic [COORD_BITS-1:0] center_x_q, center_y_q;
	logic [RADIUS_W-1:0]   radius_q;
	logic                  mode_q;
	logic                  cfg_we;
	reg_idx_t              cfg_idx;
	logic [RADIUS_W-1:0]   divisor;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= RADIUS_W'(1);
			mode_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CENTER_X: center_x_q <= pwdata[COORD_BITS-1:0];
				REG_CENTER_Y: center_y_q <= pwdata[COORD_BITS-1:0];
				REG_RADIUS:   radius_q   <= pwdata[RADIUS_W-1:0];
				REG_MODE:     mode_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_CENTER_X: prdata = 32'(center_x_q);
			REG_CENTER_Y: prdata = 32'(center_y_q);
			REG_RADIUS:   prdata = 32'(radius_q);
			REG_MODE:     prdata = 32'(mode_q);
			default:      prdata = '0;
		endcase
	end

	// a zero radius divides as one
	assign divisor = (radius_q == '0) ? RADIUS_W'(1) : radius_q;

	// ---- front stage: colour sum and squared distance ----
	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] adx, ady;
	logic [D2_W-1:0]       d2;
	logic                  v_s1, rdy_s1;
	sqrt_t                 sq_s1;
	logic                  rdy_sq0;

	always_comb begin
		dx  = {1'b0, pixel_x} - {1'b0, center_x_q};
		dy  = {1'b0, pixel_y} - {1'b0, center_y_q};
		adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
		ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
		d2  = D2_W'(adx * adx) + D2_W'(ady * ady);
	end

	assign rdy_s1   = !v_s1 || rdy_sq0;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sq_s1.rad  <= RAD_W'({d2, 16'b0});
			sq_s1.rem  <= '0;
			sq_s1.root <= '0;
			sq_s1.sum  <= SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		end
	end

	// ---- square root row ----
	logic  sq_v   [0:ROOT_W];
	logic  sq_rdy [0:ROOT_W];
	sqrt_t sq_d   [0:ROOT_W];

	assign sq_v[0] = v_s1;
	assign sq_d[0] = sq_s1;
	assign rdy_sq0 = sq_rdy[0];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		rfg_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_v[i]),
			.in_ready  (sq_rdy[i]),
			.in_data   (sq_d[i]),
			.out_valid (sq_v[i+1]),
			.out_ready (sq_rdy[i+1]),
			.out_data  (sq_d[i+1])
		);
	end

	// ---- divider row ----
	logic dv_v   [0:NUM_W];
	logic dv_rdy [0:NUM_W];
	div_t dv_d   [0:NUM_W];

	assign dv_v[0]        = sq_v[ROOT_W];
	assign sq_rdy[ROOT_W] = dv_rdy[0];
	assign dv_d[0].nq     = {sq_d[ROOT_W].root, 8'b0};
	assign dv_d[0].rem    = '0;
	assign dv_d[0].sum    = sq_d[ROOT_W].sum;

	for (genvar j = 0; j < NUM_W; j++) begin : g_div
		rfg_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.divisor   (divisor),
			.in_valid  (dv_v[j]),
			.in_ready  (dv_rdy[j]),
			.in_data   (dv_d[j]),
			.out_valid (dv_v[j+1]),
			.out_ready (dv_rdy[j+1]),
			.out_data  (dv_d[j+1])
		);
	end

	// ---- fade factor and product ----
	logic [RATIO_W-1:0] ratio_c;
	logic [RATIO_W:0]   fac_s;
	logic [RATIO_W:0]   fac_a;
	logic [FAC_W-1:0]   fac;
	logic               v_s2, rdy_s2;
	logic [PROD_W-1:0]  prod_s2;
	logic               rdy_o;

	always_comb begin
		ratio_c = (dv_d[NUM_W].nq > NUM_W'(RATIO_CLAMP)) ? RATIO_CLAMP
			: dv_d[NUM_W].nq[RATIO_W-1:0];
		fac_s = Q16_ONE - {1'b0, ratio_c};
		if (fac_s[RATIO_W]) begin
			fac_a = mode_q ? (RATIO_W+1)'(-fac_s) : '0;
		end else begin
			fac_a = fac_s;
		end
		fac = (fac_a > (RATIO_W+1)'(FAC_MAX)) ? FAC_MAX : fac_a[FAC_W-1:0];
	end

	assign rdy_s2        = !v_s2 || rdy_o;
	assign dv_rdy[NUM_W] = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= dv_v[NUM_W];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && dv_v[NUM_W]) begin
			prod_s2 <= PROD_W'(dv_d[NUM_W].sum * fac);
		end
	end

	// ---- divide by three, saturate, output register ----
	logic [PROD_W-17:0] hi;
	logic [PROD_W:0]    q3_full;
	logic [PROD_W-17:0] q3;
	logic               out_valid_q;
	logic [7:0]         gray_q;

	always_comb begin
		hi      = prod_s2[PROD_W-1:16];
		q3_full = (PROD_W+1)'(hi * RECIP3);
		q3      = q3_full[PROD_W-17+17:17];
	end

	assign rdy_o = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_s2) begin
			gray_q <= (q3 > (PROD_W-16)'(255)) ? 8'hFF : q3[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign gray      = gray_q;

	// ---- assertions ----
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		divisor != '0)
		else $error("divisor is zero");

	a_front_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1)
		else $error("input stalled with empty front stage");

	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx == REG_MODE) |=> mode_q == $past(pwdata[0]))
		else $error("fade mode write lost");

endmodule
